FILE: rtl/lehmer_rng_range_draw_assert.svh
// Assertion macros shared by the datapath and controller RTL files.
`ifndef LEHMER_RNG_RANGE_DRAW_ASSERT_SVH
`define LEHMER_RNG_RANGE_DRAW_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LRD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrd assertion failed");

// Next-cycle implication, checked out of reset.
`define LRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrd assertion failed");

`endif

FILE: rtl/lrd_pkg.sv
`default_nettype none

package lrd_pkg;

  localparam int STATE_W = 31;
  localparam int MULT_W  = 16;
  localparam int PROD_W  = STATE_W + MULT_W;
  localparam int K_W     = 16;
  localparam int DATA_W  = 32;
  localparam int D_W     = DATA_W + 2;
  localparam int U_W     = K_W + 2;
  localparam int SP_W    = D_W + U_W;
  localparam int SHIFT   = K_W + 1;

  localparam logic [MULT_W-1:0]  LEHMER_MULT = 16'd48271;
  localparam logic [STATE_W-1:0] ZERO_FIX    = 31'd3399;
  localparam logic [STATE_W-1:0] SEED_RESET  = 31'd4660;
  localparam logic [STATE_W-1:0] SEED_ZERO   = 31'd1;

  localparam logic OP_INT  = 1'b0;
  localparam logic OP_REAL = 1'b1;

  typedef struct packed {
    logic load_seed;
    logic load_in;
    logic fold;
    logic scale;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/lrd_datapath.sv
`default_nettype none
`include "lehmer_rng_range_draw_assert.svh"

module lrd_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  lrd_pkg::cmd_t                      cmd,
  output lrd_pkg::sts_t                      sts,
  input  logic [lrd_pkg::STATE_W-1:0]        seed_value,
  input  logic                               operation,
  input  logic signed [lrd_pkg::DATA_W-1:0]  range_low,
  input  logic signed [lrd_pkg::DATA_W-1:0]  range_high,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [lrd_pkg::DATA_W-1:0]  draw_value,
  output logic [lrd_pkg::K_W-1:0]            unit_fraction,
  output logic [lrd_pkg::STATE_W-1:0]        state_value
);
  import lrd_pkg::*;

  logic [STATE_W-1:0]       gen_state;
  logic [PROD_W-1:0]        prod;
  logic signed [D_W-1:0]    d_r;
  logic signed [DATA_W-1:0] lo_r;
  logic signed [SP_W-1:0]   scaled;

  logic [PROD_W-1:0]        prod_next;
  logic [STATE_W:0]         fold_sum;
  logic                     fold_ge;
  logic [STATE_W-1:0]       fold_red;
  logic [STATE_W-1:0]       fold_state;
  logic [STATE_W-1:0]       seed_fix;
  logic signed [D_W-1:0]    d_next;
  logic signed [D_W-1:0]    hi_ext;
  logic signed [D_W-1:0]    lo_ext;
  logic signed [U_W-1:0]    unit_odd;

  assign prod_next = PROD_W'(gen_state) * PROD_W'(LEHMER_MULT);
  assign fold_sum  = {1'b0, prod[STATE_W-1:0]} + (STATE_W+1)'(prod[PROD_W-1:STATE_W]);
  assign fold_ge   = fold_sum[STATE_W] | (&fold_sum[STATE_W-1:0]);
  assign fold_red  = fold_ge ? (fold_sum[STATE_W-1:0] + STATE_W'(1))
                             : fold_sum[STATE_W-1:0];
  assign fold_state = (fold_red == '0) ? ZERO_FIX : fold_red;
  assign seed_fix   = (seed_value == '0) ? SEED_ZERO : seed_value;

  assign hi_ext = {{(D_W-DATA_W){range_high[DATA_W-1]}}, range_high};
  assign lo_ext = {{(D_W-DATA_W){range_low[DATA_W-1]}}, range_low};
  assign d_next = hi_ext - lo_ext + ((operation == OP_INT) ? D_W'(1) : D_W'(0));
  assign unit_odd = $signed({1'b0, gen_state[K_W-1:0], 1'b1});

  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= SEED_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_seed) begin
        gen_state <= seed_fix;
      end else if (cmd.fold) begin
        gen_state <= fold_state;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      prod <= prod_next;
      d_r  <= d_next;
      lo_r <= range_low;
    end
    if (cmd.scale) begin
      scaled <= unit_odd * d_r;
    end
    if (cmd.load_out) begin
      draw_value    <= scaled[SHIFT+DATA_W-1:SHIFT] + lo_r;
      unit_fraction <= gen_state[K_W-1:0];
      state_value   <= gen_state;
    end
  end

  `LRD_ASSERT_NOW(a_state_nonzero, clk, rst, 1'b1, gen_state != '0)
  `LRD_ASSERT_NEXT(a_load_out_valid, clk, rst, cmd.load_out, out_valid)
  `LRD_ASSERT_NEXT(a_fold_below_mod, clk, rst, cmd.fold, gen_state != '1)

endmodule

`default_nettype wire

FILE: rtl/lrd_ctrl.sv
`default_nettype none
`include "lehmer_rng_range_draw_assert.svh"

module lrd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          in_valid,
  output logic          in_stall,
  input  lrd_pkg::sts_t sts,
  output lrd_pkg::cmd_t cmd
);
  import lrd_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FOLD  = 2'd1;
  localparam logic [1:0] ST_SCALE = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       in_take;

  assign in_stall  = (state != ST_IDLE) || cfg_valid;
  assign cfg_ready = (state == ST_IDLE);
  assign in_take   = in_valid && !in_stall;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.load_seed = cfg_valid && cfg_ready;
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          cmd.load_in = 1'b1;
          state_next  = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `LRD_ASSERT_NEXT(a_take_to_fold, clk, rst, in_take, state == ST_FOLD)
  `LRD_ASSERT_NOW(a_out_only_free, clk, rst, cmd.load_out, sts.out_free)
  `LRD_ASSERT_NOW(a_seed_only_idle, clk, rst, cmd.load_seed, !cmd.fold && state == ST_IDLE)

endmodule

`default_nettype wire

FILE: rtl/lehmer_rng_range_draw.sv
// Lehmer random range draw (multiplier 48271, modulus 2^31-1).
// Input channel: in_valid / in_stall with operation, range_low, range_high.
//   An item is taken when in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with draw_value, unit_fraction and
//   state_value; a result is taken when out_valid is high and out_stall low.
// Seed channel: cfg_valid / cfg_ready with seed_value; a write reloads the
//   generator state (zero loads one). Write only while no item is in flight;
//   a pending write stalls the input.
// The result is loaded into the output register in the last of the four
//   controller steps (take and multiply, modular fold, range multiply, output
//   load), which run one at a time; the next item is taken after the load.
// The output register holds a finished result while the next item is taken;
//   a stalled receiver holds the result and, once the next one is ready,
//   the block waits in its output step and stalls the input.
// Reset (rst, synchronous): state goes to 4660, out_valid and controller clear.
`default_nettype none

module lehmer_rng_range_draw (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lrd_pkg::STATE_W-1:0]        seed_value,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               operation,
  input  logic signed [lrd_pkg::DATA_W-1:0]  range_low,
  input  logic signed [lrd_pkg::DATA_W-1:0]  range_high,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [lrd_pkg::DATA_W-1:0]  draw_value,
  output logic [lrd_pkg::K_W-1:0]            unit_fraction,
  output logic [lrd_pkg::STATE_W-1:0]        state_value
);
  import lrd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lrd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lrd_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .seed_value    (seed_value),
    .operation     (operation),
    .range_low     (range_low),
    .range_high    (range_high),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .draw_value    (draw_value),
    .unit_fraction (unit_fraction),
    .state_value   (state_value)
  );

endmodule

`default_nettype wire
